>>> hw/rtl/chs_pkg.sv
// chs_pkg: constants, widths and action codes for the chained hash set
// used by the top level and the port checker; depends on nothing
package chs_pkg;
    localparam int MAX_BUCKETS   = 1024;
    localparam int START_BUCKETS = 16;
    localparam int VAL_W  = 32;
    localparam int SLOT_W = $clog2(MAX_BUCKETS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = SLOT_W;
    localparam int BKT_W  = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_BUCKETS);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BUCKETS - 1);
    localparam logic [BKT_W-1:0]  BKT_START = BKT_W'(START_BUCKETS);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TEST   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
endpackage

>>> hw/rtl/chs_ram.sv
// chs_ram: generic single write port, single read port ram, registered read
// no dependencies
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/chained_hash_set.sv
// chained_hash_set: separate chaining hash set of 32-bit values
// an item reads its bucket head and walks the chain; an add then takes a free or fresh slot
// and inserts, a remove unlinks; a resize gathers the old buckets' entries, clears the new
// buckets and relinks every entry
// items are taken one at a time; the next item can be taken once the result appears
// reset clears control at once, then a clearing pass empties the 16 bucket heads
// depends on chs_pkg and chs_ram
module chained_hash_set (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic signed [chs_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic                              full_res,
    output logic [chs_pkg::CNT_W-1:0]         entry_count,
    output logic [chs_pkg::BKT_W-1:0]         bucket_count
);
    import chs_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_HEAD   = 16'h0004,
        S_WALK   = 16'h0008,
        S_DECIDE = 16'h0010,
        S_ALLOC  = 16'h0020,
        S_INSERT = 16'h0040,
        S_UNLINK = 16'h0080,
        S_GB     = 16'h0100,
        S_GH     = 16'h0200,
        S_GL     = 16'h0400,
        S_R0     = 16'h0800,
        S_R1     = 16'h1000,
        S_R2     = 16'h2000,
        S_R3     = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // control
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [SLOT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0]  ftop_reg, ftop_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic              rehash_reg, rehash_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  gcnt_reg, gcnt_next;

    // payload
    logic [1:0]        act_reg, act_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [SLOT_W-1:0] bkt_reg, bkt_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] hlink_reg, hlink_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BKT_W-1:0]  newtot_reg, newtot_next;
    logic              okr_reg, okr_next;
    logic              fullr_reg, fullr_next;
    logic              ok_reg, ok_next;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  ecnt_reg, ecnt_next;
    logic [BKT_W-1:0]  bcnt_reg, bcnt_next;

    // memories
    logic              head_we;
    logic [SLOT_W-1:0] head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rdata;
    logic              val_we;
    logic [SLOT_W-1:0] val_waddr, val_raddr;
    logic [VAL_W-1:0]  val_wdata, val_rdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;
    logic              free_we;
    logic [CNT_W-1:0]  free_waddr, free_raddr;
    logic [SLOT_W-1:0] free_wdata, free_rdata;
    logic              gath_we;
    logic [CNT_W-1:0]  gath_waddr, gath_raddr;
    logic [SLOT_W-1:0] gath_wdata, gath_rdata;

    logic [SLOT_W-1:0] bmask;
    logic [CNT_W-1:0]  stored_dec;
    logic              out_free;

    assign bmask      = SLOT_W'(bucket_reg - BKT_W'(1));
    assign stored_dec = stored_reg - CNT_W'(1);
    assign out_free   = !out_valid_reg || !out_stall;

    chs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    chs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_BUCKETS)) u_val (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );
    chs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );
    chs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BUCKETS)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );
    chs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BUCKETS)) u_gath (
        .clk(clk), .we(gath_we), .waddr(gath_waddr), .wdata(gath_wdata),
        .raddr(gath_raddr), .rdata(gath_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        stored_next    = stored_reg;
        fresh_next     = fresh_reg;
        ftop_next      = ftop_reg;
        bucket_next    = bucket_reg;
        rehash_next    = rehash_reg;
        idx_next       = idx_reg;
        gcnt_next      = gcnt_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        bkt_next       = bkt_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        hlink_next     = hlink_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        newtot_next    = newtot_reg;
        okr_next       = okr_reg;
        fullr_next     = fullr_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        ecnt_next      = ecnt_reg;
        bcnt_next      = bcnt_reg;

        head_we = 1'b0; head_waddr = '0; head_wdata = NIL_LINK; head_raddr = '0;
        val_we  = 1'b0; val_waddr  = '0; val_wdata  = val_reg;  val_raddr  = '0;
        link_we = 1'b0; link_waddr = '0; link_wdata = NIL_LINK; link_raddr = '0;
        free_we = 1'b0; free_waddr = '0; free_wdata = '0;       free_raddr = '0;
        gath_we = 1'b0; gath_waddr = '0; gath_wdata = '0;       gath_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = idx_reg;
                head_wdata = NIL_LINK;
                idx_next   = idx_reg + SLOT_W'(1);
                if (idx_reg == bmask)
                begin
                    idx_next    = '0;
                    rehash_next = 1'b0;
                    state_next  = rehash_reg ? S_R0 : S_IDLE;
                end
            end
            S_IDLE:
            begin
                head_raddr = value[SLOT_W-1:0] & bmask;
                if (in_valid)
                begin
                    act_next   = action;
                    val_next   = value;
                    bkt_next   = value[SLOT_W-1:0] & bmask;
                    found_next = 1'b0;
                    okr_next   = 1'b0;
                    fullr_next = 1'b0;
                    prev_next  = NIL_LINK;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                head_next  = head_rdata;
                cur_next   = head_rdata;
                val_raddr  = head_rdata[SLOT_W-1:0];
                link_raddr = head_rdata[SLOT_W-1:0];
                state_next = (head_rdata == NIL_LINK) ? S_DECIDE : S_WALK;
            end
            S_WALK:
            begin
                if (val_rdata == val_reg)
                begin
                    found_next = 1'b1;
                    hlink_next = link_rdata;
                    state_next = S_DECIDE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    val_raddr  = link_rdata[SLOT_W-1:0];
                    link_raddr = link_rdata[SLOT_W-1:0];
                    if (link_rdata == NIL_LINK)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        if (found_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else if (stored_reg == CNT_MAX)
                        begin
                            fullr_next = 1'b1;
                        end
                        else if (ftop_reg != '0)
                        begin
                            free_raddr = ftop_reg - CNT_W'(1);
                            ftop_next  = ftop_reg - CNT_W'(1);
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            slot_next  = fresh_reg;
                            fresh_next = fresh_reg + SLOT_W'(1);
                            state_next = S_INSERT;
                        end
                    end
                    ACT_TEST:
                    begin
                        okr_next = found_reg;
                    end
                    ACT_REMOVE:
                    begin
                        if (found_reg && stored_reg != '0)
                        begin
                            state_next = S_UNLINK;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                slot_next  = free_rdata;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                val_we      = 1'b1;
                val_waddr   = slot_reg;
                val_wdata   = val_reg;
                link_we     = 1'b1;
                link_waddr  = slot_reg;
                link_wdata  = head_reg;
                head_we     = 1'b1;
                head_waddr  = bkt_reg;
                head_wdata  = {1'b0, slot_reg};
                stored_next = stored_reg + CNT_W'(1);
                okr_next    = 1'b1;
                state_next  = S_DONE;
                if (BKT_W'(stored_reg) + BKT_W'(1) == bucket_reg)
                begin
                    newtot_next = {bucket_reg[BKT_W-2:0], 1'b0};
                    state_next  = S_GB;
                end
            end
            S_UNLINK:
            begin
                if (prev_reg == NIL_LINK)
                begin
                    head_we    = 1'b1;
                    head_waddr = bkt_reg;
                    head_wdata = hlink_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[SLOT_W-1:0];
                    link_wdata = hlink_reg;
                end
                free_we     = 1'b1;
                free_waddr  = ftop_reg;
                free_wdata  = cur_reg[SLOT_W-1:0];
                ftop_next   = ftop_reg + CNT_W'(1);
                stored_next = stored_dec;
                okr_next    = 1'b1;
                state_next  = S_DONE;
                if (bucket_reg > BKT_START && {stored_dec, 2'b00} <= {1'b0, bucket_reg})
                begin
                    newtot_next = {1'b0, bucket_reg[BKT_W-1:1]};
                    state_next  = S_GB;
                end
            end
            S_GB:
            begin
                idx_next   = '0;
                gcnt_next  = '0;
                head_raddr = '0;
                state_next = S_GH;
            end
            S_GH, S_GL:
            begin
                // gather every slot of the old buckets, then shrink or grow
                if ((state_reg == S_GH ? head_rdata : link_rdata) != NIL_LINK)
                begin
                    gath_we    = 1'b1;
                    gath_waddr = gcnt_reg;
                    gath_wdata = (state_reg == S_GH) ? head_rdata[SLOT_W-1:0]
                                                     : link_rdata[SLOT_W-1:0];
                    gcnt_next  = gcnt_reg + CNT_W'(1);
                    link_raddr = gath_wdata;
                    state_next = S_GL;
                end
                else if (idx_reg == bmask)
                begin
                    bucket_next = newtot_reg;
                    idx_next    = '0;
                    rehash_next = 1'b1;
                    state_next  = S_CLEAR;
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    head_raddr = idx_reg + SLOT_W'(1);
                    state_next = S_GH;
                end
            end
            S_R0:
            begin
                gath_raddr = idx_reg;
                state_next = S_R1;
            end
            S_R1:
            begin
                slot_next  = gath_rdata;
                val_raddr  = gath_rdata;
                state_next = S_R2;
            end
            S_R2:
            begin
                bkt_next   = val_rdata[SLOT_W-1:0] & bmask;
                head_raddr = val_rdata[SLOT_W-1:0] & bmask;
                state_next = S_R3;
            end
            S_R3:
            begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = head_rdata;
                head_we    = 1'b1;
                head_waddr = bkt_reg;
                head_wdata = {1'b0, slot_reg};
                idx_next   = idx_reg + SLOT_W'(1);
                state_next = S_R0;
                if (CNT_W'(idx_reg) + CNT_W'(1) == gcnt_reg)
                begin
                    idx_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = okr_reg;
                    full_next      = fullr_reg;
                    ecnt_next      = stored_reg;
                    bcnt_next      = bucket_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            stored_reg    <= '0;
            fresh_reg     <= '0;
            ftop_reg      <= '0;
            bucket_reg    <= BKT_START;
            rehash_reg    <= 1'b0;
            idx_reg       <= '0;
            gcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            stored_reg    <= stored_next;
            fresh_reg     <= fresh_next;
            ftop_reg      <= ftop_next;
            bucket_reg    <= bucket_next;
            rehash_reg    <= rehash_next;
            idx_reg       <= idx_next;
            gcnt_reg      <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        bkt_reg    <= bkt_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        hlink_reg  <= hlink_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        newtot_reg <= newtot_next;
        okr_reg    <= okr_next;
        fullr_reg  <= fullr_next;
        ok_reg     <= ok_next;
        full_reg   <= full_next;
        ecnt_reg   <= ecnt_next;
        bcnt_reg   <= bcnt_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign full_res     = full_reg;
    assign entry_count  = ecnt_reg;
    assign bucket_count = bcnt_reg;
endmodule

>>> hw/rtl/chs_checker.sv
// chs_checker: port level assertions for chained_hash_set, bound to the top level
// depends on chs_pkg
module chs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [1:0]                action,
    input logic [chs_pkg::VAL_W-1:0] value,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      ok,
    input logic                      full_res,
    input logic [chs_pkg::CNT_W-1:0] entry_count,
    input logic [chs_pkg::BKT_W-1:0] bucket_count
);
    import chs_pkg::*;

    // a held item keeps its counts
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_count)
                                   && $stable(bucket_count))
        else $error("held item changed");

    a_bkt_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(bucket_count) && bucket_count >= BKT_START)
        else $error("bucket count not a power of two in range");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> BKT_W'(entry_count) < bucket_count)
        else $error("entries not below buckets");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_res |-> !ok && entry_count == CNT_MAX && action == action)
        else $error("full item inconsistent");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && $stable(value) || in_stall)
        else $error("input taken twice in a row");
endmodule

bind chained_hash_set chs_checker u_chs_checker (.*);

>>> tb/testbench.sv
// testbench for chained_hash_set: directed, random and fill/drain item streams
// checked against a set-based predictor held in a small scoreboard class
// depends on chs_pkg and the chained_hash_set rtl
`timescale 1ns / 1ps

module testbench;
    import chs_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic                ok;
        logic                full_res;
        logic [CNT_W-1:0]    entry_count;
        logic [BKT_W-1:0]    bucket_count;
    } set_result_t;

    class set_scoreboard;
        bit          members[bit [31:0]];
        int unsigned stored;
        int unsigned buckets;
        set_result_t awaited[$];
        int          errors;
        int          results_seen;
        int          full_seen;
        int          max_buckets_seen;

        function new();
            stored = 0;
            buckets = START_BUCKETS;
            errors = 0;
            results_seen = 0;
            full_seen = 0;
            max_buckets_seen = START_BUCKETS;
        endfunction

        // work out the result of one accepted item and queue it
        function void note_item(logic [1:0] act, logic [31:0] val);
            set_result_t r;
            bit present;
            present = members.exists(val);
            r.ok = 1'b0;
            r.full_res = 1'b0;
            case (act)
                ACT_ADD:
                begin
                    if (!present)
                    begin
                        if (stored + 1 >= MAX_BUCKETS)
                            r.full_res = 1'b1;
                        else
                        begin
                            members[val] = 1'b1;
                            stored++;
                            r.ok = 1'b1;
                            if (stored == buckets)
                                buckets = buckets * 2;
                        end
                    end
                end
                ACT_TEST:
                    r.ok = present;
                ACT_REMOVE:
                begin
                    if (present)
                    begin
                        members.delete(val);
                        stored--;
                        r.ok = 1'b1;
                        if (buckets > START_BUCKETS && 4 * stored <= buckets)
                            buckets = buckets / 2;
                    end
                end
                default:
                    ;
            endcase
            if (buckets > max_buckets_seen)
                max_buckets_seen = buckets;
            r.entry_count = CNT_W'(stored);
            r.bucket_count = BKT_W'(buckets);
            awaited.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(set_result_t got);
            set_result_t want;
            results_seen++;
            if (got.full_res)
                full_seen++;
            if (awaited.size() == 0)
            begin
                report("unexpected result, ok", got.ok, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.ok !== want.ok)
                report("ok", got.ok, want.ok);
            if (got.full_res !== want.full_res)
                report("full_res", got.full_res, want.full_res);
            if (got.entry_count !== want.entry_count)
                report("entry_count", got.entry_count, want.entry_count);
            if (got.bucket_count !== want.bucket_count)
                report("bucket_count", got.bucket_count, want.bucket_count);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            action = ACT_TEST;
    logic signed [31:0]    value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  ok;
    logic                  full_res;
    logic [CNT_W-1:0]      entry_count;
    logic [BKT_W-1:0]      bucket_count;

    set_scoreboard sb = new();
    bit            quiet_send = 1'b0;
    bit            quiet_recv = 1'b0;
    int            recv_hold = 0;
    logic [31:0]   pool[64];
    logic [31:0]   filled[$];

    chained_hash_set dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .full_res(full_res),
        .entry_count(entry_count), .bucket_count(bucket_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: stall for a drawn number of cycles before each result
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_stall <= 1'b1;
            recv_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result('{ok, full_res, entry_count, bucket_count});
            recv_hold = quiet_recv ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 99) == 0)
                quiet_recv = !quiet_recv;
        end
    end

    // valid stays up into the next item when there is no gap
    task send_item(logic [1:0] act, logic [31:0] val);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 99) == 0)
            quiet_send = !quiet_send;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        value <= val;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(act, val);
        @(negedge clk);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return pool[$urandom_range(0, 63)];
        else if (sel == 6)
            return 32'h8000_0000 | ($urandom_range(0, 3) << 4);
        else
            return $urandom;
    endfunction

    initial
    begin
        int   k;
        int   w;
        logic [1:0]  act;
        logic [31:0] v;

        for (k = 0; k < 64; k++)
            pool[k] = (k < 32) ? (32'(k) << 4) ^ 32'(k % 3) : $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every action, duplicates, absent removes, shared buckets
        send_item(ACT_TEST, 32'h0);
        send_item(ACT_ADD, 32'h0);
        send_item(ACT_ADD, 32'h0);
        send_item(ACT_TEST, 32'h0);
        send_item(ACT_ADD, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 32'h8000_0000);
        send_item(ACT_ADD, 32'h7FFF_FFFF);
        send_item(ACT_ADD, 32'h10);
        send_item(ACT_ADD, 32'h20);
        send_item(ACT_ADD, 32'hFFFF_FFF0);
        send_item(ACT_TEST, 32'h20);
        send_item(ACT_REMOVE, 32'h10);
        send_item(ACT_TEST, 32'h10);
        send_item(ACT_TEST, 32'h20);
        send_item(ACT_REMOVE, 32'h10);
        send_item(ACT_REMOVE, 32'h1234_5678);
        send_item(ACT_NONE, 32'hFFFF_FFFF);
        send_item(ACT_NONE, 32'h0);
        send_item(ACT_TEST, 32'hFFFF_FFFF);
        send_item(ACT_REMOVE, 32'hFFFF_FFFF);
        send_item(ACT_REMOVE, 32'h8000_0000);

        // grow from 16 to 32 buckets and shrink back
        for (k = 0; k < 20; k++)
            send_item(ACT_ADD, 32'h100 + 32'(k));
        for (k = 0; k < 18; k++)
            send_item(ACT_REMOVE, 32'h100 + 32'(k));

        // random mix on a small pool so adds, hits and misses all happen
        for (k = 0; k < 100; k++)
        begin
            w = $urandom_range(0, 19);
            if (k % 40 < 25)
                act = (w < 10) ? ACT_ADD : (w < 15) ? ACT_TEST : (w < 19) ? ACT_REMOVE : ACT_NONE;
            else
                act = (w < 5) ? ACT_ADD : (w < 10) ? ACT_TEST : (w < 19) ? ACT_REMOVE : ACT_NONE;
            send_item(act, pick_value());
        end

        // hold off until the block has answered everything
        wait_drained();

        // fill to the limit, push a few refused adds, then remove a random part
        while (sb.stored < MAX_BUCKETS - 1)
        begin
            v = $urandom;
            if (!sb.members.exists(v))
                filled.push_back(v);
            send_item(ACT_ADD, v);
        end
        for (k = 0; k < 6; k++)
            send_item((k % 2) ? ACT_TEST : ACT_ADD, $urandom);
        send_item(ACT_ADD, filled[0]);
        filled.shuffle();
        for (k = 0; k < 100; k++)
        begin
            v = filled.pop_front();
            send_item(ACT_REMOVE, v);
            if ($urandom_range(0, 7) == 0)
                send_item(ACT_TEST, v);
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("covered %0d results, %0d refused adds, up to %0d buckets",
                 sb.results_seen, sb.full_seen, sb.max_buckets_seen);
        $display("run went through a small grow and shrink, then growth to the full limit");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout with %0d items outstanding", sb.awaited.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule
